[hw/rtl/hpack_huffman_encoder_top_macros.svh]
// Assertion macros for the HPACK Huffman encoder RTL.
// Used by the controller only; no other dependencies.
`ifndef HPACK_HUFFMAN_ENCODER_TOP_MACROS_SVH
`define HPACK_HUFFMAN_ENCODER_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define HPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hpe assertion failed");

// Next-cycle implication outside reset.
`define HPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hpe assertion failed");

`endif

[hw/rtl/hpe_pkg.sv]
// Shared types, constants and the RFC 7541 code table for the HPACK encoder.
// No dependencies.
package hpe_pkg;

	localparam int CODE_W = 30;
	localparam int LEN_W  = 5;
	localparam int ACC_W  = 37;
	localparam int TOT_W  = 6;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} hcode_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic emit;
		logic pad;
	} hpe_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic has_byte;
		logic one_left;
		logic has_part;
		logic last_q;
	} hpe_sts_t;

	function automatic hcode_t hpe_lookup(input logic [7:0] sym);
		hcode_t r;
		logic [31:0] c;
		logic [4:0] l;
		begin
			c = 32'h0;
			l = 5'd0;
			case (sym)
				8'd0: begin c = 32'h1ff8; l = 5'd13; end
				8'd1: begin c = 32'h7fffd8; l = 5'd23; end
				8'd2: begin c = 32'hfffffe2; l = 5'd28; end
				8'd3: begin c = 32'hfffffe3; l = 5'd28; end
				8'd4: begin c = 32'hfffffe4; l = 5'd28; end
				8'd5: begin c = 32'hfffffe5; l = 5'd28; end
				8'd6: begin c = 32'hfffffe6; l = 5'd28; end
				8'd7: begin c = 32'hfffffe7; l = 5'd28; end
				8'd8: begin c = 32'hfffffe8; l = 5'd28; end
				8'd9: begin c = 32'hffffea; l = 5'd24; end
				8'd10: begin c = 32'h3ffffffc; l = 5'd30; end
				8'd11: begin c = 32'hfffffe9; l = 5'd28; end
				8'd12: begin c = 32'hfffffea; l = 5'd28; end
				8'd13: begin c = 32'h3ffffffd; l = 5'd30; end
				8'd14: begin c = 32'hfffffeb; l = 5'd28; end
				8'd15: begin c = 32'hfffffec; l = 5'd28; end
				8'd16: begin c = 32'hfffffed; l = 5'd28; end
				8'd17: begin c = 32'hfffffee; l = 5'd28; end
				8'd18: begin c = 32'hfffffef; l = 5'd28; end
				8'd19: begin c = 32'hffffff0; l = 5'd28; end
				8'd20: begin c = 32'hffffff1; l = 5'd28; end
				8'd21: begin c = 32'hffffff2; l = 5'd28; end
				8'd22: begin c = 32'h3ffffffe; l = 5'd30; end
				8'd23: begin c = 32'hffffff3; l = 5'd28; end
				8'd24: begin c = 32'hffffff4; l = 5'd28; end
				8'd25: begin c = 32'hffffff5; l = 5'd28; end
				8'd26: begin c = 32'hffffff6; l = 5'd28; end
				8'd27: begin c = 32'hffffff7; l = 5'd28; end
				8'd28: begin c = 32'hffffff8; l = 5'd28; end
				8'd29: begin c = 32'hffffff9; l = 5'd28; end
				8'd30: begin c = 32'hffffffa; l = 5'd28; end
				8'd31: begin c = 32'hffffffb; l = 5'd28; end
				8'd32: begin c = 32'h14; l = 5'd6; end
				8'd33: begin c = 32'h3f8; l = 5'd10; end
				8'd34: begin c = 32'h3f9; l = 5'd10; end
				8'd35: begin c = 32'hffa; l = 5'd12; end
				8'd36: begin c = 32'h1ff9; l = 5'd13; end
				8'd37: begin c = 32'h15; l = 5'd6; end
				8'd38: begin c = 32'hf8; l = 5'd8; end
				8'd39: begin c = 32'h7fa; l = 5'd11; end
				8'd40: begin c = 32'h3fa; l = 5'd10; end
				8'd41: begin c = 32'h3fb; l = 5'd10; end
				8'd42: begin c = 32'hf9; l = 5'd8; end
				8'd43: begin c = 32'h7fb; l = 5'd11; end
				8'd44: begin c = 32'hfa; l = 5'd8; end
				8'd45: begin c = 32'h16; l = 5'd6; end
				8'd46: begin c = 32'h17; l = 5'd6; end
				8'd47: begin c = 32'h18; l = 5'd6; end
				8'd48: begin c = 32'h0; l = 5'd5; end
				8'd49: begin c = 32'h1; l = 5'd5; end
				8'd50: begin c = 32'h2; l = 5'd5; end
				8'd51: begin c = 32'h19; l = 5'd6; end
				8'd52: begin c = 32'h1a; l = 5'd6; end
				8'd53: begin c = 32'h1b; l = 5'd6; end
				8'd54: begin c = 32'h1c; l = 5'd6; end
				8'd55: begin c = 32'h1d; l = 5'd6; end
				8'd56: begin c = 32'h1e; l = 5'd6; end
				8'd57: begin c = 32'h1f; l = 5'd6; end
				8'd58: begin c = 32'h5c; l = 5'd7; end
				8'd59: begin c = 32'hfb; l = 5'd8; end
				8'd60: begin c = 32'h7ffc; l = 5'd15; end
				8'd61: begin c = 32'h20; l = 5'd6; end
				8'd62: begin c = 32'hffb; l = 5'd12; end
				8'd63: begin c = 32'h3fc; l = 5'd10; end
				8'd64: begin c = 32'h1ffa; l = 5'd13; end
				8'd65: begin c = 32'h21; l = 5'd6; end
				8'd66: begin c = 32'h5d; l = 5'd7; end
				8'd67: begin c = 32'h5e; l = 5'd7; end
				8'd68: begin c = 32'h5f; l = 5'd7; end
				8'd69: begin c = 32'h60; l = 5'd7; end
				8'd70: begin c = 32'h61; l = 5'd7; end
				8'd71: begin c = 32'h62; l = 5'd7; end
				8'd72: begin c = 32'h63; l = 5'd7; end
				8'd73: begin c = 32'h64; l = 5'd7; end
				8'd74: begin c = 32'h65; l = 5'd7; end
				8'd75: begin c = 32'h66; l = 5'd7; end
				8'd76: begin c = 32'h67; l = 5'd7; end
				8'd77: begin c = 32'h68; l = 5'd7; end
				8'd78: begin c = 32'h69; l = 5'd7; end
				8'd79: begin c = 32'h6a; l = 5'd7; end
				8'd80: begin c = 32'h6b; l = 5'd7; end
				8'd81: begin c = 32'h6c; l = 5'd7; end
				8'd82: begin c = 32'h6d; l = 5'd7; end
				8'd83: begin c = 32'h6e; l = 5'd7; end
				8'd84: begin c = 32'h6f; l = 5'd7; end
				8'd85: begin c = 32'h70; l = 5'd7; end
				8'd86: begin c = 32'h71; l = 5'd7; end
				8'd87: begin c = 32'h72; l = 5'd7; end
				8'd88: begin c = 32'hfc; l = 5'd8; end
				8'd89: begin c = 32'h73; l = 5'd7; end
				8'd90: begin c = 32'hfd; l = 5'd8; end
				8'd91: begin c = 32'h1ffb; l = 5'd13; end
				8'd92: begin c = 32'h7fff0; l = 5'd19; end
				8'd93: begin c = 32'h1ffc; l = 5'd13; end
				8'd94: begin c = 32'h3ffc; l = 5'd14; end
				8'd95: begin c = 32'h22; l = 5'd6; end
				8'd96: begin c = 32'h7ffd; l = 5'd15; end
				8'd97: begin c = 32'h3; l = 5'd5; end
				8'd98: begin c = 32'h23; l = 5'd6; end
				8'd99: begin c = 32'h4; l = 5'd5; end
				8'd100: begin c = 32'h24; l = 5'd6; end
				8'd101: begin c = 32'h5; l = 5'd5; end
				8'd102: begin c = 32'h25; l = 5'd6; end
				8'd103: begin c = 32'h26; l = 5'd6; end
				8'd104: begin c = 32'h27; l = 5'd6; end
				8'd105: begin c = 32'h6; l = 5'd5; end
				8'd106: begin c = 32'h74; l = 5'd7; end
				8'd107: begin c = 32'h75; l = 5'd7; end
				8'd108: begin c = 32'h28; l = 5'd6; end
				8'd109: begin c = 32'h29; l = 5'd6; end
				8'd110: begin c = 32'h2a; l = 5'd6; end
				8'd111: begin c = 32'h7; l = 5'd5; end
				8'd112: begin c = 32'h2b; l = 5'd6; end
				8'd113: begin c = 32'h76; l = 5'd7; end
				8'd114: begin c = 32'h2c; l = 5'd6; end
				8'd115: begin c = 32'h8; l = 5'd5; end
				8'd116: begin c = 32'h9; l = 5'd5; end
				8'd117: begin c = 32'h2d; l = 5'd6; end
				8'd118: begin c = 32'h77; l = 5'd7; end
				8'd119: begin c = 32'h78; l = 5'd7; end
				8'd120: begin c = 32'h79; l = 5'd7; end
				8'd121: begin c = 32'h7a; l = 5'd7; end
				8'd122: begin c = 32'h7b; l = 5'd7; end
				8'd123: begin c = 32'h7ffe; l = 5'd15; end
				8'd124: begin c = 32'h7fc; l = 5'd11; end
				8'd125: begin c = 32'h3ffd; l = 5'd14; end
				8'd126: begin c = 32'h1ffd; l = 5'd13; end
				8'd127: begin c = 32'hffffffc; l = 5'd28; end
				8'd128: begin c = 32'hfffe6; l = 5'd20; end
				8'd129: begin c = 32'h3fffd2; l = 5'd22; end
				8'd130: begin c = 32'hfffe7; l = 5'd20; end
				8'd131: begin c = 32'hfffe8; l = 5'd20; end
				8'd132: begin c = 32'h3fffd3; l = 5'd22; end
				8'd133: begin c = 32'h3fffd4; l = 5'd22; end
				8'd134: begin c = 32'h3fffd5; l = 5'd22; end
				8'd135: begin c = 32'h7fffd9; l = 5'd23; end
				8'd136: begin c = 32'h3fffd6; l = 5'd22; end
				8'd137: begin c = 32'h7fffda; l = 5'd23; end
				8'd138: begin c = 32'h7fffdb; l = 5'd23; end
				8'd139: begin c = 32'h7fffdc; l = 5'd23; end
				8'd140: begin c = 32'h7fffdd; l = 5'd23; end
				8'd141: begin c = 32'h7fffde; l = 5'd23; end
				8'd142: begin c = 32'hffffeb; l = 5'd24; end
				8'd143: begin c = 32'h7fffdf; l = 5'd23; end
				8'd144: begin c = 32'hffffec; l = 5'd24; end
				8'd145: begin c = 32'hffffed; l = 5'd24; end
				8'd146: begin c = 32'h3fffd7; l = 5'd22; end
				8'd147: begin c = 32'h7fffe0; l = 5'd23; end
				8'd148: begin c = 32'hffffee; l = 5'd24; end
				8'd149: begin c = 32'h7fffe1; l = 5'd23; end
				8'd150: begin c = 32'h7fffe2; l = 5'd23; end
				8'd151: begin c = 32'h7fffe3; l = 5'd23; end
				8'd152: begin c = 32'h7fffe4; l = 5'd23; end
				8'd153: begin c = 32'h1fffdc; l = 5'd21; end
				8'd154: begin c = 32'h3fffd8; l = 5'd22; end
				8'd155: begin c = 32'h7fffe5; l = 5'd23; end
				8'd156: begin c = 32'h3fffd9; l = 5'd22; end
				8'd157: begin c = 32'h7fffe6; l = 5'd23; end
				8'd158: begin c = 32'h7fffe7; l = 5'd23; end
				8'd159: begin c = 32'hffffef; l = 5'd24; end
				8'd160: begin c = 32'h3fffda; l = 5'd22; end
				8'd161: begin c = 32'h1fffdd; l = 5'd21; end
				8'd162: begin c = 32'hfffe9; l = 5'd20; end
				8'd163: begin c = 32'h3fffdb; l = 5'd22; end
				8'd164: begin c = 32'h3fffdc; l = 5'd22; end
				8'd165: begin c = 32'h7fffe8; l = 5'd23; end
				8'd166: begin c = 32'h7fffe9; l = 5'd23; end
				8'd167: begin c = 32'h1fffde; l = 5'd21; end
				8'd168: begin c = 32'h7fffea; l = 5'd23; end
				8'd169: begin c = 32'h3fffdd; l = 5'd22; end
				8'd170: begin c = 32'h3fffde; l = 5'd22; end
				8'd171: begin c = 32'hfffff0; l = 5'd24; end
				8'd172: begin c = 32'h1fffdf; l = 5'd21; end
				8'd173: begin c = 32'h3fffdf; l = 5'd22; end
				8'd174: begin c = 32'h7fffeb; l = 5'd23; end
				8'd175: begin c = 32'h7fffec; l = 5'd23; end
				8'd176: begin c = 32'h1fffe0; l = 5'd21; end
				8'd177: begin c = 32'h1fffe1; l = 5'd21; end
				8'd178: begin c = 32'h3fffe0; l = 5'd22; end
				8'd179: begin c = 32'h1fffe2; l = 5'd21; end
				8'd180: begin c = 32'h7fffed; l = 5'd23; end
				8'd181: begin c = 32'h3fffe1; l = 5'd22; end
				8'd182: begin c = 32'h7fffee; l = 5'd23; end
				8'd183: begin c = 32'h7fffef; l = 5'd23; end
				8'd184: begin c = 32'hfffea; l = 5'd20; end
				8'd185: begin c = 32'h3fffe2; l = 5'd22; end
				8'd186: begin c = 32'h3fffe3; l = 5'd22; end
				8'd187: begin c = 32'h3fffe4; l = 5'd22; end
				8'd188: begin c = 32'h7ffff0; l = 5'd23; end
				8'd189: begin c = 32'h3fffe5; l = 5'd22; end
				8'd190: begin c = 32'h3fffe6; l = 5'd22; end
				8'd191: begin c = 32'h7ffff1; l = 5'd23; end
				8'd192: begin c = 32'h3ffffe0; l = 5'd26; end
				8'd193: begin c = 32'h3ffffe1; l = 5'd26; end
				8'd194: begin c = 32'hfffeb; l = 5'd20; end
				8'd195: begin c = 32'h7fff1; l = 5'd19; end
				8'd196: begin c = 32'h3fffe7; l = 5'd22; end
				8'd197: begin c = 32'h7ffff2; l = 5'd23; end
				8'd198: begin c = 32'h3fffe8; l = 5'd22; end
				8'd199: begin c = 32'h1ffffec; l = 5'd25; end
				8'd200: begin c = 32'h3ffffe2; l = 5'd26; end
				8'd201: begin c = 32'h3ffffe3; l = 5'd26; end
				8'd202: begin c = 32'h3ffffe4; l = 5'd26; end
				8'd203: begin c = 32'h7ffffde; l = 5'd27; end
				8'd204: begin c = 32'h7ffffdf; l = 5'd27; end
				8'd205: begin c = 32'h3ffffe5; l = 5'd26; end
				8'd206: begin c = 32'hfffff1; l = 5'd24; end
				8'd207: begin c = 32'h1ffffed; l = 5'd25; end
				8'd208: begin c = 32'h7fff2; l = 5'd19; end
				8'd209: begin c = 32'h1fffe3; l = 5'd21; end
				8'd210: begin c = 32'h3ffffe6; l = 5'd26; end
				8'd211: begin c = 32'h7ffffe0; l = 5'd27; end
				8'd212: begin c = 32'h7ffffe1; l = 5'd27; end
				8'd213: begin c = 32'h3ffffe7; l = 5'd26; end
				8'd214: begin c = 32'h7ffffe2; l = 5'd27; end
				8'd215: begin c = 32'hfffff2; l = 5'd24; end
				8'd216: begin c = 32'h1fffe4; l = 5'd21; end
				8'd217: begin c = 32'h1fffe5; l = 5'd21; end
				8'd218: begin c = 32'h3ffffe8; l = 5'd26; end
				8'd219: begin c = 32'h3ffffe9; l = 5'd26; end
				8'd220: begin c = 32'hffffffd; l = 5'd28; end
				8'd221: begin c = 32'h7ffffe3; l = 5'd27; end
				8'd222: begin c = 32'h7ffffe4; l = 5'd27; end
				8'd223: begin c = 32'h7ffffe5; l = 5'd27; end
				8'd224: begin c = 32'hfffec; l = 5'd20; end
				8'd225: begin c = 32'hfffff3; l = 5'd24; end
				8'd226: begin c = 32'hfffed; l = 5'd20; end
				8'd227: begin c = 32'h1fffe6; l = 5'd21; end
				8'd228: begin c = 32'h3fffe9; l = 5'd22; end
				8'd229: begin c = 32'h1fffe7; l = 5'd21; end
				8'd230: begin c = 32'h1fffe8; l = 5'd21; end
				8'd231: begin c = 32'h7ffff3; l = 5'd23; end
				8'd232: begin c = 32'h3fffea; l = 5'd22; end
				8'd233: begin c = 32'h3fffeb; l = 5'd22; end
				8'd234: begin c = 32'h1ffffee; l = 5'd25; end
				8'd235: begin c = 32'h1ffffef; l = 5'd25; end
				8'd236: begin c = 32'hfffff4; l = 5'd24; end
				8'd237: begin c = 32'hfffff5; l = 5'd24; end
				8'd238: begin c = 32'h3ffffea; l = 5'd26; end
				8'd239: begin c = 32'h7ffff4; l = 5'd23; end
				8'd240: begin c = 32'h3ffffeb; l = 5'd26; end
				8'd241: begin c = 32'h7ffffe6; l = 5'd27; end
				8'd242: begin c = 32'h3ffffec; l = 5'd26; end
				8'd243: begin c = 32'h3ffffed; l = 5'd26; end
				8'd244: begin c = 32'h7ffffe7; l = 5'd27; end
				8'd245: begin c = 32'h7ffffe8; l = 5'd27; end
				8'd246: begin c = 32'h7ffffe9; l = 5'd27; end
				8'd247: begin c = 32'h7ffffea; l = 5'd27; end
				8'd248: begin c = 32'h7ffffeb; l = 5'd27; end
				8'd249: begin c = 32'hffffffe; l = 5'd28; end
				8'd250: begin c = 32'h7ffffec; l = 5'd27; end
				8'd251: begin c = 32'h7ffffed; l = 5'd27; end
				8'd252: begin c = 32'h7ffffee; l = 5'd27; end
				8'd253: begin c = 32'h7ffffef; l = 5'd27; end
				8'd254: begin c = 32'h7fffff0; l = 5'd27; end
				8'd255: begin c = 32'h3ffffee; l = 5'd26; end
				default: begin c = 32'h0; l = 5'd0; end
			endcase
			r.code = c[CODE_W-1:0];
			r.len  = l;
			return r;
		end
	endfunction

endpackage

[hw/rtl/hpe_datapath.sv]
// Bit accumulator datapath of the HPACK encoder: code lookup, append, byte extraction.
// Depends on hpe_pkg.
module hpe_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  hpe_pkg::hpe_cmd_t cmd,
	output hpe_pkg::hpe_sts_t sts,
	output logic [7:0]        byte_d
);
	import hpe_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [TOT_W-1:0] total_q;
	logic             last_q;
	hcode_t           hc;
	logic [ACC_W-1:0] shifted;
	logic [ACC_W-1:0] pend;
	logic [TOT_W-1:0] shamt;
	logic [7:0]       part;
	logic [2:0]       fill;

	assign hc = hpe_lookup(in_byte);
	// Only the low total_q bits of the accumulator are live.
	assign pend = acc_q & ((ACC_W'(1) << total_q) - ACC_W'(1));
	assign shamt = total_q - TOT_W'(8);
	assign shifted = acc_q >> shamt;
	assign fill = 3'(TOT_W'(8) - total_q);
	assign part = (8'(acc_q) << fill) | ((8'd1 << fill) - 8'd1);

	assign sts.has_byte = (total_q >= TOT_W'(8));
	assign sts.one_left = (total_q == TOT_W'(8));
	assign sts.has_part = (total_q != '0);
	assign sts.last_q   = last_q;
	assign byte_d = cmd.pad ? part : shifted[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			total_q <= '0;
			last_q  <= 1'b0;
		end else if (cmd.load) begin
			acc_q   <= (pend << hc.len) | ACC_W'(hc.code);
			total_q <= total_q + TOT_W'(hc.len);
			last_q  <= in_last;
		end else if (cmd.emit) begin
			total_q <= total_q - TOT_W'(8);
		end else if (cmd.pad) begin
			total_q <= '0;
		end
	end

endmodule

[hw/rtl/hpe_ctrl.sv]
// Controller of the HPACK encoder: sequences load, byte emission and padding.
// Depends on hpe_pkg and the assertion macro header.
module hpe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              out_last,
	output logic              out_take,
	input  hpe_pkg::hpe_sts_t sts,
	output hpe_pkg::hpe_cmd_t cmd
);
	import hpe_pkg::*;
	`include "hpack_huffman_encoder_top_macros.svh"

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_RUN  = 1'b1;

	logic [0:0] state_q;
	logic       ovalid_q;
	logic       olast_q;
	logic       slot_free;
	logic       want_pad;
	logic       is_final;

	assign slot_free = !ovalid_q || !out_stall;
	assign want_pad  = sts.last_q && !sts.has_byte && sts.has_part;
	// A full byte is final when it is the only one left and the string ends here.
	assign is_final  = sts.last_q && (sts.has_byte ? sts.one_left : 1'b1);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ovalid_q;
	assign out_last  = olast_q;

	always_comb begin
		cmd = '0;
		out_take = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_RUN: begin
				if (slot_free) begin
					cmd.emit = sts.has_byte;
					cmd.pad  = want_pad;
					out_take = sts.has_byte || want_pad;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			olast_q  <= 1'b0;
		end else begin
			if (out_take) begin
				ovalid_q <= 1'b1;
				olast_q  <= is_final;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_RUN;
				ST_RUN:  if (slot_free && !out_take) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`HPE_ASSERT_IMP(a_no_load_busy, clk, arst_n, state_q == ST_RUN, !cmd.load)
	`HPE_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1, $onehot0({cmd.load, cmd.emit, cmd.pad}))
	`HPE_ASSERT_IMP(a_take_slot, clk, arst_n, out_take, slot_free)

endmodule

[hw/rtl/hpack_huffman_encoder_top.sv]
// Channel   Signals                          Direction
// input     in_valid in_stall in_byte in_last    into block
// output    out_valid out_stall out_byte out_last out of block
// Each item is loaded, then emits its output bytes (0 to 5), then returns to idle;
// one byte leaves per cycle while the output is not stalled.
// arst_n clears the bit accumulator, its count and all valid flags.
// A stalled output byte freezes emission; input is stalled until the item finishes.
// Top level of the HPACK Huffman encoder; depends on hpe_pkg, hpe_ctrl, hpe_datapath.
module hpack_huffman_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import hpe_pkg::*;

	hpe_cmd_t   cmd;
	hpe_sts_t   sts;
	logic [7:0] byte_d;
	logic       out_take;
	logic [7:0] obyte_q;

	hpe_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.out_last, .out_take, .sts, .cmd
	);

	hpe_datapath u_dp (
		.clk, .arst_n, .in_byte, .in_last, .cmd, .sts, .byte_d
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obyte_q <= '0;
		end else if (out_take) begin
			obyte_q <= byte_d;
		end
	end
	assign out_byte = obyte_q;

endmodule

[tb/tb_hpack_huffman_encoder_top.sv]
// Self-checking testbench for the HPACK Huffman encoder top level.
// Depends on hpack_huffman_encoder_top (and through it on hpe_pkg); builds its own code table.
module tb_hpack_huffman_encoder_top;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       out_last;

	hpack_huffman_encoder_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
		.out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte), .out_last(out_last)
	);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} packed_byte_t;

	// Code lengths of RFC 7541 Appendix B; the codes themselves are canonical and rebuilt below.
	int unsigned code_len [256] = '{
		13,23,28,28,28,28,28,28, 28,24,30,28,28,30,28,28,
		28,28,28,28,28,28,30,28, 28,28,28,28,28,28,28,28,
		6,10,10,12,13,6,8,11,    10,10,8,11,8,6,6,6,
		5,5,5,6,6,6,6,6,         6,6,7,8,15,6,12,10,
		13,6,7,7,7,7,7,7,        7,7,7,7,7,7,7,7,
		7,7,7,7,7,7,7,7,         8,7,8,13,19,13,14,6,
		15,5,6,5,6,5,6,6,        6,5,7,7,6,6,6,5,
		6,7,6,5,5,6,7,7,         7,7,7,15,11,14,13,28,
		20,22,20,20,22,22,22,23, 22,23,23,23,23,23,24,23,
		24,24,22,23,24,23,23,23, 23,21,22,23,22,23,23,24,
		22,21,20,22,22,23,23,21, 23,22,22,24,21,22,23,23,
		21,21,22,21,23,22,23,23, 20,22,22,22,23,22,22,23,
		26,26,20,19,22,23,22,25, 26,26,26,27,27,26,24,25,
		19,21,26,27,27,26,27,24, 21,21,26,26,28,27,27,27,
		20,24,20,21,22,21,21,23, 22,22,25,25,24,24,26,23,
		26,27,26,26,27,27,27,27, 27,28,27,27,27,27,27,26
	};
	logic [29:0] code_val [256];

	packed_byte_t expected_bytes [$];
	logic [6:0]   acc_bits;
	int unsigned  acc_count;
	int unsigned  mismatches;
	int unsigned  cycles;
	int unsigned  stall_hold;

	localparam int unsigned CYCLE_LIMIT = 1000000;

	function automatic void build_codes();
		logic [29:0] c;
		c = '0;
		for (int unsigned l = 5; l <= 30; l++) begin
			for (int s = 0; s < 256; s++) begin
				if (code_len[s] == l) begin
					code_val[s] = c;
					c++;
				end
			end
			c = c << 1;
		end
	endfunction

	// Appends the code behind the pending bits; if keep, queues each full byte and any padded tail.
	function automatic void pack_symbol(input logic [7:0] sym, input logic last, input bit keep);
		logic [36:0] acc;
		int unsigned total;
		int unsigned fill;
		int unsigned n;
		packed_byte_t pb;
		n = 0;
		acc = 37'(acc_bits & 7'((1 << acc_count) - 1));
		acc = (acc << code_len[sym]) | 37'(code_val[sym]);
		total = acc_count + code_len[sym];
		while (total >= 8) begin
			pb.data = 8'(acc >> (total - 8));
			pb.last = 1'b0;
			if (keep) expected_bytes.push_back(pb);
			n++;
			total -= 8;
		end
		acc &= (37'd1 << total) - 37'd1;
		if (last) begin
			if (total > 0) begin
				fill = 8 - total;
				pb.data = 8'((acc << fill) | ((37'd1 << fill) - 37'd1));
				pb.last = 1'b0;
				if (keep) expected_bytes.push_back(pb);
				n++;
			end
			if (keep && n > 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
			acc_bits = '0;
			acc_count = 0;
		end else begin
			acc_bits = acc[6:0];
			acc_count = total;
		end
	endfunction

	task automatic report(input string what, input logic [7:0] got_b, input logic got_l,
			input logic [7:0] exp_b, input logic exp_l);
		$display("mismatch %s: got byte %02h last %0b, expected byte %02h last %0b",
			what, got_b, got_l, exp_b, exp_l);
		mismatches++;
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(30, 5);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Output checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				report("unexpected item", out_byte, out_last, 8'h00, 1'b0);
			end else begin
				if (out_byte !== expected_bytes[0].data || out_last !== expected_bytes[0].last)
					report("field", out_byte, out_last,
						expected_bytes[0].data, expected_bytes[0].last);
				void'(expected_bytes.pop_front());
			end
		end
	end

	// Receiver: random stalls, with long holds on request.
	initial begin
		int unsigned run;
		bit stalling;
		out_stall = 1'b0;
		run = 0;
		stalling = 0;
		forever begin
			@(negedge clk);
			if (stall_hold > 0) begin
				out_stall <= 1'b1;
				stall_hold--;
			end else begin
				if (run == 0) begin
					stalling = !stalling;
					run = stalling ? pick_gap() : $urandom_range(40, 1);
				end
				if (run > 0) run--;
				out_stall <= stalling && run > 0;
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic l, input int unsigned gap,
			input bit keep);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= l;
		do @(posedge clk); while (in_stall);
		pack_symbol(b, l, keep);
		@(negedge clk);
	endtask

	typedef struct {
		logic [7:0] b;
		logic       l;
		int         n_typed;
		logic [7:0] typed [4];
	} stim_row_t;

	stim_row_t rows [] = '{
		'{8'd48,  1'b1, 1, '{8'h07, 8'h00, 8'h00, 8'h00}},
		'{8'd97,  1'b1, 1, '{8'h1f, 8'h00, 8'h00, 8'h00}},
		'{8'd10,  1'b1, 4, '{8'hff, 8'hff, 8'hff, 8'hf3}},
		'{8'd38,  1'b1, 1, '{8'hf8, 8'h00, 8'h00, 8'h00}},
		'{8'd0,   1'b0, 0, '{default: 8'h00}},
		'{8'd255, 1'b1, 0, '{default: 8'h00}},
		'{8'd13,  1'b0, 0, '{default: 8'h00}},
		'{8'd22,  1'b0, 0, '{default: 8'h00}},
		'{8'd10,  1'b0, 0, '{default: 8'h00}},
		'{8'd48,  1'b1, 0, '{default: 8'h00}},
		'{8'd49,  1'b0, 0, '{default: 8'h00}},
		'{8'd50,  1'b0, 0, '{default: 8'h00}},
		'{8'd38,  1'b0, 0, '{default: 8'h00}},
		'{8'd65,  1'b1, 0, '{default: 8'h00}},
		'{8'd128, 1'b0, 0, '{default: 8'h00}},
		'{8'd127, 1'b0, 0, '{default: 8'h00}},
		'{8'd254, 1'b0, 0, '{default: 8'h00}},
		'{8'd170, 1'b1, 0, '{default: 8'h00}},
		'{8'd85,  1'b0, 0, '{default: 8'h00}},
		'{8'd101, 1'b1, 0, '{default: 8'h00}},
		'{8'd249, 1'b1, 0, '{default: 8'h00}}
	};

	initial begin
		int unsigned len;
		logic [7:0] b;
		packed_byte_t pb;
		build_codes();
		acc_bits = '0;
		acc_count = 0;
		mismatches = 0;
		cycles = 0;
		stall_hold = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		in_last = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].n_typed > 0) begin
				for (int k = 0; k < rows[i].n_typed; k++) begin
					pb.data = rows[i].typed[k];
					pb.last = (k == rows[i].n_typed - 1);
					expected_bytes.push_back(pb);
				end
			end
			send_item(rows[i].b, rows[i].l, pick_gap(), rows[i].n_typed == 0);
		end

		for (int sent = 0; sent < 350; ) begin
			if (sent >= 150 && sent < 160 && stall_hold == 0) stall_hold = 300;
			if (sent >= 250 && sent < 258) begin
				in_valid <= 1'b0;
				wait (expected_bytes.size() == 0);
				@(negedge clk);
			end
			len = $urandom_range(8, 1);
			for (int k = 0; k < len; k++) begin
				// About half text bytes, mostly with short codes; the rest fully random bytes.
				if ($urandom_range(1)) b = 8'($urandom_range(122, 32));
				else b = 8'($urandom);
				send_item(b, k == len - 1, pick_gap(), 1'b1);
				sent++;
			end
		end
		in_valid <= 1'b0;

		wait (expected_bytes.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
